// ===== rtl/cfsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsb_pkg
// Shared types, byte codes and the CRC-8 step for the framed SPI bridge.
// ----------------------------------------------------------------------------
package cfsb_pkg;

  // Frame magic and fixed bytes
  localparam logic [7:0] MAGIC_N   = 8'h4E;
  localparam logic [7:0] MAGIC_Q   = 8'h51;
  localparam logic [7:0] ERR_LEN   = 8'h02;
  localparam logic [7:0] ERR_MARK  = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h07;

  // Error codes sent in the error frame
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_CRC     = 2'd2;
  localparam logic [1:0] ERR_LENGTH  = 2'd3;

  // Destination codes
  localparam logic DEST_SPI  = 1'b0;
  localparam logic DEST_HOST = 1'b1;

  // Input item kinds
  localparam logic KIND_HOST = 1'b0;
  localparam logic KIND_SPI  = 1'b1;

  // Which burst the output sequencer is producing
  typedef enum logic [2:0] {
    EK_NONE,
    EK_ERR,
    EK_SPI,
    EK_RHDR,
    EK_RDAT,
    EK_RCRC
  } emit_kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       cap_ver;    // capture version, start request CRC
    logic       cap_seq;    // capture sequence
    logic       cap_len;    // clear count, capture length when good
    logic       pay_wr;     // store payload byte
    logic       rep_acc;    // take SPI reply byte
    logic       clr_cnt;    // clear byte count
    logic       set_err;    // latch error code
    logic [1:0] err_code;
    logic       load;       // load output register
    emit_kind_t emit_kind;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_n;
    logic is_q;
    logic len_bad;
    logic ver_bad;
    logic crc_bad;
    logic pay_last;
    logic rep_first;
    logic rep_last;
    logic burst_end;
  } status_t;

  // One byte of CRC-8, polynomial 0x07, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc8_framed_spi_bridge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_spi_bridge
// Host frame parser with CRC-8 check, SPI transfer issue and reply framing.
// ----------------------------------------------------------------------------
// An input byte that produces no output leaves the input ready. A byte that
// produces output blocks the input while its burst drains through the single
// output register, one byte per cycle while the output does not stall (an
// error frame is 8 bytes, a good request MAX_PAYLOAD+1 at most, a reply byte
// up to 6). The burst sequencer and the payload memory with registered read
// set this pace. The payload memory needs no clear: it is only read after the
// current frame wrote it.
module crc8_framed_spi_bridge #(
  parameter int MAX_PAYLOAD = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_dest,
  output logic [7:0]  out_out_byte,
  output logic        out_last,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_TARGET  = 1'b1;

  logic [7:0]        protocol_version_r;
  logic [7:0]        spi_target_r;
  logic              cfg_wr;
  cfsb_pkg::cmd_t    cmd;
  cfsb_pkg::status_t st;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_version_r <= 8'd1;
      spi_target_r       <= 8'd4;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_VERSION: protocol_version_r <= cfg_pwdata[7:0];
        REG_TARGET:  spi_target_r       <= cfg_pwdata[7:0];
        default:     protocol_version_r <= protocol_version_r;
      endcase
    end
  end

  // Register readback; low address bits are ignored
  always_comb begin
    unique case (cfg_paddr[2])
      REG_VERSION: cfg_prdata = 32'(protocol_version_r);
      REG_TARGET:  cfg_prdata = 32'(spi_target_r);
      default:     cfg_prdata = 32'd0;
    endcase
  end

  cfsb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .st          (st),
    .cmd         (cmd)
  );

  cfsb_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_data_byte     (in_data_byte),
    .protocol_version (protocol_version_r),
    .spi_target       (spi_target_r),
    .out_dest         (out_dest),
    .out_out_byte     (out_out_byte),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/cfsb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsb_dp
// Frame fields, payload memory, CRC registers, burst counter and output
// register of the framed SPI bridge.
// ----------------------------------------------------------------------------
module cfsb_dp #(
  parameter int MAX_PAYLOAD = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfsb_pkg::cmd_t    cmd,
  output cfsb_pkg::status_t st,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        protocol_version,
  input  logic [7:0]        spi_target,
  output logic              out_dest,
  output logic [7:0]        out_out_byte,
  output logic              out_last
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int KW = (LW > 3) ? LW : 3;
  localparam logic [7:0] MAX8 = 8'(MAX_PAYLOAD);

  logic [7:0]    frame_version_r;
  logic [7:0]    frame_sequence_r;
  logic [LW-1:0] frame_length_r;
  logic [LW-1:0] byte_count_r;
  logic [7:0]    request_crc_r;
  logic [7:0]    tx_crc_r;
  logic [7:0]    rep_byte_r;
  logic [1:0]    err_code_r;
  logic [KW-1:0] k_r;
  logic [KW-1:0] k_nxt;
  logic [7:0]    payload_mem [MAX_PAYLOAD];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [7:0]    crc_base;
  logic [7:0]    crc_next;
  logic [KW-1:0] len_k;
  logic [7:0]    total_byte;
  logic [LW:0]   count_inc;

  logic [7:0]    tx_byte;
  logic          tx_dest;
  logic          tx_last;
  logic          tx_crc_clr;
  logic          tx_crc_add;
  logic          burst_end;

  assign len_k      = KW'(frame_length_r);
  assign total_byte = 8'(frame_length_r) + 8'd1;
  assign count_inc  = (LW + 1)'(byte_count_r) + (LW + 1)'(1);

  // Status toward the controller
  always_comb begin
    st.is_n      = (in_data_byte == cfsb_pkg::MAGIC_N);
    st.is_q      = (in_data_byte == cfsb_pkg::MAGIC_Q);
    st.len_bad   = (in_data_byte == 8'd0) || (in_data_byte > MAX8);
    st.ver_bad   = (frame_version_r != protocol_version);
    st.crc_bad   = (request_crc_r != in_data_byte);
    st.pay_last  = (count_inc >= (LW + 1)'(frame_length_r));
    st.rep_first = (byte_count_r == '0);
    st.rep_last  = (byte_count_r >= frame_length_r);
    st.burst_end = burst_end;
  end

  // Request CRC, stepped over the version, sequence, length and payload bytes
  assign crc_base = cmd.cap_ver ? 8'd0 : request_crc_r;
  assign crc_next = cfsb_pkg::crc8_step(crc_base, in_data_byte);

  // Capture frame fields and count bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_version_r  <= '0;
      frame_sequence_r <= '0;
      frame_length_r   <= '0;
      byte_count_r     <= '0;
      request_crc_r    <= '0;
    end else begin
      if (cmd.cap_ver) begin
        frame_version_r <= in_data_byte;
        request_crc_r   <= crc_next;
      end
      if (cmd.cap_seq) begin
        frame_sequence_r <= in_data_byte;
        request_crc_r    <= crc_next;
      end
      if (cmd.cap_len) begin
        byte_count_r <= '0;
        if (!st.len_bad) begin
          frame_length_r <= in_data_byte[LW-1:0];
          request_crc_r  <= crc_next;
        end
      end
      if (cmd.pay_wr) begin
        request_crc_r <= crc_next;
        byte_count_r  <= count_inc[LW-1:0];
      end
      if (cmd.rep_acc) begin
        byte_count_r <= st.rep_last ? '0 : count_inc[LW-1:0];
      end
      if (cmd.clr_cnt) begin
        byte_count_r <= '0;
      end
    end
  end

  // Hold reply byte and error code for the burst
  always_ff @(posedge clk) begin
    if (cmd.rep_acc) begin
      rep_byte_r <= in_data_byte;
    end
    if (cmd.set_err) begin
      err_code_r <= cmd.err_code;
    end
  end

  // Payload memory, registered read one step ahead of the burst counter
  assign rd_addr = (k_nxt == '0) ? '0 : AW'(k_nxt - KW'(1));

  always_ff @(posedge clk) begin
    if (cmd.pay_wr) begin
      payload_mem[byte_count_r[AW-1:0]] <= in_data_byte;
    end
    rd_data_r <= payload_mem[rd_addr];
  end

  // Select the byte of the current burst
  always_comb begin
    tx_byte    = 8'd0;
    tx_dest    = cfsb_pkg::DEST_HOST;
    tx_last    = 1'b0;
    tx_crc_clr = 1'b0;
    tx_crc_add = 1'b0;
    burst_end  = 1'b0;
    case (cmd.emit_kind)
      cfsb_pkg::EK_ERR: begin
        burst_end  = (k_r == KW'(7));
        tx_last    = burst_end;
        tx_crc_clr = (k_r == KW'(0));
        tx_crc_add = (k_r >= KW'(2)) && (k_r <= KW'(6));
        case (k_r)
          KW'(0):  tx_byte = cfsb_pkg::MAGIC_Q;
          KW'(1):  tx_byte = cfsb_pkg::MAGIC_N;
          KW'(2):  tx_byte = protocol_version;
          KW'(3):  tx_byte = frame_sequence_r;
          KW'(4):  tx_byte = cfsb_pkg::ERR_LEN;
          KW'(5):  tx_byte = cfsb_pkg::ERR_MARK;
          KW'(6):  tx_byte = 8'(err_code_r);
          default: tx_byte = tx_crc_r;
        endcase
      end
      cfsb_pkg::EK_SPI: begin
        burst_end = (k_r == len_k);
        tx_last   = burst_end;
        tx_dest   = cfsb_pkg::DEST_SPI;
        tx_byte   = (k_r == '0) ? spi_target : rd_data_r;
      end
      cfsb_pkg::EK_RHDR: begin
        burst_end  = (k_r == KW'(4));
        tx_crc_clr = (k_r == KW'(0));
        tx_crc_add = (k_r >= KW'(2));
        case (k_r)
          KW'(0):  tx_byte = cfsb_pkg::MAGIC_Q;
          KW'(1):  tx_byte = cfsb_pkg::MAGIC_N;
          KW'(2):  tx_byte = protocol_version;
          KW'(3):  tx_byte = frame_sequence_r;
          default: tx_byte = total_byte;
        endcase
      end
      cfsb_pkg::EK_RDAT: begin
        burst_end  = 1'b1;
        tx_crc_add = 1'b1;
        tx_byte    = rep_byte_r;
      end
      cfsb_pkg::EK_RCRC: begin
        burst_end = 1'b1;
        tx_last   = 1'b1;
        tx_byte   = tx_crc_r;
      end
      default: begin
        burst_end = 1'b0;
      end
    endcase
  end

  // Advance the burst counter on each loaded byte
  always_comb begin
    k_nxt = k_r;
    if (cmd.load) begin
      k_nxt = burst_end ? '0 : k_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  // Outgoing frame CRC and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (tx_crc_clr) begin
        tx_crc_r <= 8'd0;
      end else if (tx_crc_add) begin
        tx_crc_r <= cfsb_pkg::crc8_step(tx_crc_r, tx_byte);
      end
      out_dest     <= tx_dest;
      out_out_byte <= tx_byte;
      out_last     <= tx_last;
    end
  end

endmodule

// ===== rtl/cfsb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsb_ctrl
// Frame parser and burst sequencer of the framed SPI bridge.
// ----------------------------------------------------------------------------
module cfsb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  output logic              out_valid,
  input  logic              out_ready,
  input  cfsb_pkg::status_t st,
  output cfsb_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    PH_MAGIC_N,
    PH_MAGIC_Q,
    PH_VERSION,
    PH_SEQUENCE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CRC,
    PH_REPLY
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SPI,
    S_RHDR,
    S_RDAT,
    S_RCRC
  } state_t;

  phase_t phase_r, phase_nxt;
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   reply_end_r, reply_end_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.emit_kind = cfsb_pkg::EK_NONE;
    phase_nxt     = phase_r;
    state_nxt     = state_r;
    reply_end_nxt = reply_end_r;

    // Map burst state to the datapath selector
    unique case (state_r)
      S_ERR:   cmd.emit_kind = cfsb_pkg::EK_ERR;
      S_SPI:   cmd.emit_kind = cfsb_pkg::EK_SPI;
      S_RHDR:  cmd.emit_kind = cfsb_pkg::EK_RHDR;
      S_RDAT:  cmd.emit_kind = cfsb_pkg::EK_RDAT;
      S_RCRC:  cmd.emit_kind = cfsb_pkg::EK_RCRC;
      default: cmd.emit_kind = cfsb_pkg::EK_NONE;
    endcase

    // Load a byte whenever the output register is free
    cmd.load = (state_r != S_IDLE) && (!out_valid_r || out_ready);
    out_valid_nxt = cmd.load ? 1'b1 : (out_valid_r && !out_ready);

    if (cmd.load && st.burst_end) begin
      unique case (state_r)
        S_RHDR:  state_nxt = S_RDAT;
        S_RDAT:  state_nxt = reply_end_r ? S_RCRC : S_IDLE;
        default: state_nxt = S_IDLE;
      endcase
    end

    // Parse one accepted transfer; items of the wrong kind drop
    if (accept) begin
      if (phase_r == PH_REPLY) begin
        if (in_req_type == cfsb_pkg::KIND_SPI) begin
          cmd.rep_acc   = 1'b1;
          reply_end_nxt = st.rep_last;
          state_nxt     = st.rep_first ? S_RHDR : S_RDAT;
          if (st.rep_last) begin
            phase_nxt = PH_MAGIC_N;
          end
        end
      end else if (in_req_type == cfsb_pkg::KIND_HOST) begin
        unique case (phase_r)
          PH_MAGIC_N: begin
            if (st.is_n) begin
              phase_nxt = PH_MAGIC_Q;
            end
          end
          PH_MAGIC_Q: begin
            if (st.is_q) begin
              phase_nxt = PH_VERSION;
            end else if (!st.is_n) begin
              phase_nxt = PH_MAGIC_N;
            end
          end
          PH_VERSION: begin
            cmd.cap_ver = 1'b1;
            phase_nxt   = PH_SEQUENCE;
          end
          PH_SEQUENCE: begin
            cmd.cap_seq = 1'b1;
            phase_nxt   = PH_LENGTH;
          end
          PH_LENGTH: begin
            cmd.cap_len = 1'b1;
            if (st.len_bad) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = cfsb_pkg::ERR_LENGTH;
              state_nxt    = S_ERR;
              phase_nxt    = PH_MAGIC_N;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            cmd.pay_wr = 1'b1;
            if (st.pay_last) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            if (st.ver_bad) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = cfsb_pkg::ERR_VERSION;
              state_nxt    = S_ERR;
              phase_nxt    = PH_MAGIC_N;
            end else if (st.crc_bad) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = cfsb_pkg::ERR_CRC;
              state_nxt    = S_ERR;
              phase_nxt    = PH_MAGIC_N;
            end else begin
              cmd.clr_cnt = 1'b1;
              state_nxt   = S_SPI;
              phase_nxt   = PH_REPLY;
            end
          end
          default: phase_nxt = PH_MAGIC_N;
        endcase
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC_N;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      reply_end_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      reply_end_r <= reply_end_nxt;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-8 framed host-to-SPI bridge.
// ----------------------------------------------------------------------------
// A local frame parser predicts every byte that the bridge sends to SPI and
// to the host. Directed tests cover magic resync, bad length, version and
// CRC errors and one full SPI round trip. Random traffic follows, mostly
// well-formed frames with random content and replies, mixed with noise,
// wrong-kind bytes and broken frames. It runs under several register
// settings and with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb;

  localparam int PAYLOAD_MAX   = 13;
  localparam int REG_VERSION   = 0;
  localparam int REG_TARGET    = 1;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PRINT_LIMIT   = 40;
  localparam int RANDOM_ITEMS  = 105;

  typedef enum logic [2:0] {
    PH_WAIT_N, PH_WAIT_Q, PH_VERSION, PH_SEQUENCE,
    PH_LENGTH, PH_PAYLOAD, PH_CRC, PH_REPLY
  } parse_phase_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } tx_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = cfsb_pkg::KIND_HOST;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_dest;
  logic [7:0]  out_out_byte;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Bridge state as predicted
  parse_phase_t bp_phase = PH_WAIT_N;
  logic [7:0]   bp_version = 8'h00;
  logic [7:0]   bp_sequence = 8'h00;
  logic [3:0]   bp_length = 4'd0;
  logic [3:0]   bp_count = 4'd0;
  logic [7:0]   bp_payload [PAYLOAD_MAX];
  logic [7:0]   bp_req_crc = 8'h00;
  logic [7:0]   bp_rep_crc = 8'h00;
  logic [7:0]   bp_cfg_version = 8'h01;
  logic [7:0]   bp_cfg_target = 8'h04;

  tx_byte_t expected_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int bytes_seen = 0;
  int spi_bursts = 0;
  int error_frames = 0;
  int reply_frames = 0;
  int settings_used = 0;

  crc8_framed_spi_bridge #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_dest(out_dest),
    .out_out_byte(out_out_byte),
    .out_last(out_last),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // CRC-8, polynomial 0x07, MSB first, one byte
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void push_byte(input logic dest, input logic [7:0] b, input logic last);
    tx_byte_t t;
    t.dest = dest;
    t.data = b;
    t.last = last;
    expected_q.push_back(t);
  endfunction

  function automatic void queue_error_frame(input logic [1:0] code);
    logic [7:0] f [8];
    logic [7:0] c;
    f[0] = cfsb_pkg::MAGIC_Q;
    f[1] = cfsb_pkg::MAGIC_N;
    f[2] = bp_cfg_version;
    f[3] = bp_sequence;
    f[4] = cfsb_pkg::ERR_LEN;
    f[5] = cfsb_pkg::ERR_MARK;
    f[6] = {6'd0, code};
    c = 8'h00;
    for (int i = 2; i < 7; i++) c = crc8_next(c, f[i]);
    f[7] = c;
    for (int i = 0; i < 8; i++) push_byte(cfsb_pkg::DEST_HOST, f[i], i == 7);
    error_frames++;
  endfunction

  // Advance the predicted bridge by one accepted input byte
  function automatic void predict_transfer(input logic kind, input logic [7:0] b);
    logic [3:0] total;
    if (bp_phase == PH_REPLY) begin
      // host bytes are dropped while replies are pending
      if (kind == cfsb_pkg::KIND_SPI) begin
        total = bp_length + 4'd1;
        if (bp_count == 4'd0) begin
          push_byte(cfsb_pkg::DEST_HOST, cfsb_pkg::MAGIC_Q, 1'b0);
          push_byte(cfsb_pkg::DEST_HOST, cfsb_pkg::MAGIC_N, 1'b0);
          push_byte(cfsb_pkg::DEST_HOST, bp_cfg_version, 1'b0);
          push_byte(cfsb_pkg::DEST_HOST, bp_sequence, 1'b0);
          push_byte(cfsb_pkg::DEST_HOST, {4'd0, total}, 1'b0);
          bp_rep_crc = crc8_next(8'h00, bp_cfg_version);
          bp_rep_crc = crc8_next(bp_rep_crc, bp_sequence);
          bp_rep_crc = crc8_next(bp_rep_crc, {4'd0, total});
        end
        push_byte(cfsb_pkg::DEST_HOST, b, 1'b0);
        bp_rep_crc = crc8_next(bp_rep_crc, b);
        bp_count = bp_count + 4'd1;
        if (bp_count >= total) begin
          push_byte(cfsb_pkg::DEST_HOST, bp_rep_crc, 1'b1);
          bp_phase = PH_WAIT_N;
          bp_count = 4'd0;
          reply_frames++;
        end
      end
    end else if (kind == cfsb_pkg::KIND_HOST) begin
      case (bp_phase)
        PH_WAIT_N: begin
          if (b == cfsb_pkg::MAGIC_N) bp_phase = PH_WAIT_Q;
        end
        PH_WAIT_Q: begin
          if (b == cfsb_pkg::MAGIC_Q) bp_phase = PH_VERSION;
          else if (b != cfsb_pkg::MAGIC_N) bp_phase = PH_WAIT_N;
        end
        PH_VERSION: begin
          bp_version = b;
          bp_req_crc = crc8_next(8'h00, b);
          bp_phase = PH_SEQUENCE;
        end
        PH_SEQUENCE: begin
          bp_sequence = b;
          bp_req_crc = crc8_next(bp_req_crc, b);
          bp_phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          bp_count = 4'd0;
          if (b == 8'd0 || b > PAYLOAD_MAX) begin
            queue_error_frame(cfsb_pkg::ERR_LENGTH);
            bp_phase = PH_WAIT_N;
          end else begin
            bp_length = b[3:0];
            bp_req_crc = crc8_next(bp_req_crc, b);
            bp_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bp_payload[bp_count] = b;
          bp_req_crc = crc8_next(bp_req_crc, b);
          bp_count = bp_count + 4'd1;
          if (bp_count >= bp_length) bp_phase = PH_CRC;
        end
        PH_CRC: begin
          // version is checked ahead of the CRC
          if (bp_version != bp_cfg_version) begin
            queue_error_frame(cfsb_pkg::ERR_VERSION);
            bp_phase = PH_WAIT_N;
          end else if (bp_req_crc != b) begin
            queue_error_frame(cfsb_pkg::ERR_CRC);
            bp_phase = PH_WAIT_N;
          end else begin
            push_byte(cfsb_pkg::DEST_SPI, bp_cfg_target, 1'b0);
            for (int i = 0; i < bp_length; i++) begin
              push_byte(cfsb_pkg::DEST_SPI, bp_payload[i], i + 1 == bp_length);
            end
            bp_count = 4'd0;
            bp_phase = PH_REPLY;
            spi_bursts++;
          end
        end
        default: bp_phase = PH_WAIT_N;
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Compare each result transfer with the oldest expected byte
  always @(posedge clk) begin
    tx_byte_t got;
    tx_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      got.dest = out_dest;
      got.data = out_out_byte;
      got.last = out_last;
      bytes_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer dest=%0d byte=%02h last=%0d",
                                  got.dest, got.data, got.last));
      end else begin
        want = expected_q.pop_front();
        if (got.dest != want.dest)
          report_mismatch($sformatf("dest %0d, want %0d (byte %02h)",
                                    got.dest, want.dest, want.data));
        if (got.data != want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0d, want %0d (byte %02h)",
                                    got.last, want.last, want.data));
      end
    end
  end

  // Send one input byte; valid stays high on return so a following byte
  // can go out back to back
  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transfer(kind, b);
    items_sent++;
  endtask

  // Host byte, sometimes preceded by a stray SPI byte that must be dropped
  task automatic send_host(input logic [7:0] b);
    if ($urandom_range(19) == 0) send_item(cfsb_pkg::KIND_SPI, 8'($urandom_range(255)));
    send_item(cfsb_pkg::KIND_HOST, b);
  endtask

  // Drop valid and wait until every expected byte has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(idx * 4);
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic cfg_read(input int idx, output logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= 3'(idx * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    value = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write both registers while idle and read them back
  task automatic set_config(input logic [7:0] version, input logic [7:0] target);
    logic [31:0] rd;
    wait_idle();
    cfg_write(REG_VERSION, version);
    cfg_write(REG_TARGET, target);
    bp_cfg_version = version;
    bp_cfg_target = target;
    cfg_read(REG_VERSION, rd);
    if (rd[7:0] != version)
      report_mismatch($sformatf("protocol_version reads %02h, want %02h", rd[7:0], version));
    cfg_read(REG_TARGET, rd);
    if (rd[7:0] != target)
      report_mismatch($sformatf("spi_target reads %02h, want %02h", rd[7:0], target));
    settings_used++;
  endtask

  // Send a request frame; lengths outside 1..max stop after the length byte
  task automatic send_frame(input logic [7:0] version, input logic [7:0] seq,
                            input logic [7:0] len, input bit crc_good);
    logic [7:0] crc;
    send_host(cfsb_pkg::MAGIC_N);
    send_host(cfsb_pkg::MAGIC_Q);
    send_host(version);
    crc = crc8_next(8'h00, version);
    send_host(seq);
    crc = crc8_next(crc, seq);
    send_host(len);
    if (len != 8'd0 && len <= PAYLOAD_MAX) begin
      crc = crc8_next(crc, len);
      for (int i = 0; i < len; i++) begin
        logic [7:0] b;
        b = 8'($urandom_range(255));
        crc = crc8_next(crc, b);
        send_host(b);
      end
      send_host(crc_good ? crc : crc ^ 8'($urandom_range(1, 255)));
    end
  endtask

  // Feed SPI replies until the pending reply frame is complete
  task automatic finish_replies();
    while (bp_phase == PH_REPLY) begin
      if ($urandom_range(9) == 0) send_item(cfsb_pkg::KIND_HOST, 8'($urandom_range(255)));
      else send_item(cfsb_pkg::KIND_SPI, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_magic_resync();
    send_item(cfsb_pkg::KIND_SPI, 8'hA5);
    send_item(cfsb_pkg::KIND_HOST, cfsb_pkg::MAGIC_N);
    send_item(cfsb_pkg::KIND_HOST, cfsb_pkg::MAGIC_N);
    send_item(cfsb_pkg::KIND_HOST, cfsb_pkg::MAGIC_Q);
    send_item(cfsb_pkg::KIND_HOST, 8'h01);
    send_item(cfsb_pkg::KIND_HOST, 8'h00);
    send_item(cfsb_pkg::KIND_HOST, 8'h00);
  endtask

  task automatic test_bad_length();
    send_frame(8'hFF, 8'hFF, 8'd14, 1'b1);
  endtask

  task automatic test_version_check();
    send_frame(bp_cfg_version + 8'd1, 8'h10, 8'd1, 1'b0);
  endtask

  task automatic test_crc_check();
    send_frame(bp_cfg_version, 8'h20, 8'd1, 1'b0);
  endtask

  task automatic test_spi_round_trip();
    logic [7:0] crc;
    crc = crc8_next(crc8_next(crc8_next(crc8_next(8'h00, bp_cfg_version), 8'h7F),
                              8'd1), 8'hFF);
    send_item(cfsb_pkg::KIND_HOST, cfsb_pkg::MAGIC_N);
    send_item(cfsb_pkg::KIND_HOST, cfsb_pkg::MAGIC_Q);
    send_item(cfsb_pkg::KIND_HOST, bp_cfg_version);
    send_item(cfsb_pkg::KIND_HOST, 8'h7F);
    send_item(cfsb_pkg::KIND_HOST, 8'd1);
    send_item(cfsb_pkg::KIND_HOST, 8'hFF);
    send_item(cfsb_pkg::KIND_HOST, crc);
    send_item(cfsb_pkg::KIND_HOST, 8'h4E);
    send_item(cfsb_pkg::KIND_SPI, 8'h00);
    send_item(cfsb_pkg::KIND_SPI, 8'hFF);
  endtask

  // Mostly good frames with random content; the rest is noise and breakage
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [7:0] version, input logic [7:0] target);
    int start;
    int pick;
    logic [7:0] len;
    set_config(version, target);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) len = 8'(PAYLOAD_MAX);
      else if ($urandom_range(1) == 0) len = 8'($urandom_range(1, 4));
      else len = 8'($urandom_range(1, PAYLOAD_MAX));
      if (pick < 70) begin
        send_frame(bp_cfg_version, 8'($urandom_range(255)), len, 1'b1);
      end else if (pick < 78) begin
        send_frame(bp_cfg_version, 8'($urandom_range(255)), len, 1'b0);
      end else if (pick < 84) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                   $urandom_range(1) == 1);
      end else if (pick < 90) begin
        len = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(PAYLOAD_MAX + 1, 255));
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end
      finish_replies();
    end
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_magic_resync();
    test_bad_length();
    test_version_check();
    test_crc_check();
    test_spi_round_trip();

    test_random_traffic(0, 0, 8'h01, 8'h04);
    test_random_traffic(72, 0, 8'hFF, 8'hFF);
    test_random_traffic(0, 72, 8'h00, 8'h00);
    test_random_traffic(34, 34, 8'($urandom_range(255)), 8'($urandom_range(255)));

    wait_idle();
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_q.size()));
    $display("Sent %0d input bytes and checked %0d output bytes over %0d register settings.",
             items_sent, bytes_seen, settings_used);
    $display("Saw %0d SPI transfers, %0d reply frames and %0d error frames.",
             spi_bursts, reply_frames, error_frames);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: stop a hung run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
